[hw/rtl/multichannel_feedback_echo_unit_defines.svh]
// Assertion macros for the echo unit.
// Files that check their own logic include this header; it needs nothing else.
`ifndef MULTICHANNEL_FEEDBACK_ECHO_UNIT_DEFINES_SVH
`define MULTICHANNEL_FEEDBACK_ECHO_UNIT_DEFINES_SVH

`ifndef SYNTH
`define MFE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define MFE_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define MFE_ASSERT_ALWAYS(label, cond, msg)
`define MFE_ASSERT_IMPLIES(label, ante, cons, msg)
`endif

`endif

[hw/rtl/mfe_pkg.sv]
// Shared types, constants and helper functions of the echo unit.
// No dependencies; every other RTL file but mfe_delay_ram imports this package.
package mfe_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int MAX_DELAY    = 16384;

    localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CH_SLOTS = 1 << CH_W;
    localparam int POS_W    = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int LEN_W    = $clog2(MAX_DELAY + 1);
    localparam int ADDR_W   = CH_W + POS_W;

    localparam int SAMPLE_W = 17;
    localparam int GAIN_W   = 16;
    localparam int PROD_W   = SAMPLE_W + GAIN_W;

    localparam int Q_MIN = -32768;
    localparam int Q_MAX = 32768;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_INPUT_RANGE  = 2'd1,
        ST_RESULT_RANGE = 2'd2,
        ST_BAD_CHANNEL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_CHANNEL_COUNT = 3'd0,
        REG_DELAY_LENGTH  = 3'd1,
        REG_LOOP_GAIN     = 3'd2,
        REG_DELAYED_GAIN  = 3'd3,
        REG_DIRECT_GAIN   = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [2:0]                 channel;
        logic                       restart;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        status_t                    status;
        logic                       restarted;
    } out_word_t;

    typedef struct packed {
        logic [3:0]               channel_count;
        logic [14:0]              delay_length;
        logic signed [GAIN_W-1:0] loop_gain;
        logic signed [GAIN_W-1:0] delayed_gain;
        logic signed [GAIN_W-1:0] direct_gain;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        channel_count: 4'd1,
        delay_length:  15'd1,
        loop_gain:     16'sd0,
        delayed_gain:  16'sd0,
        direct_gain:   16'sd4096
    };

    // position and fill count of the channel being looked up
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] fill;
    } ring_view_t;

    // update of the ring state when a word commits
    typedef struct packed {
        logic             en;
        logic             clear;
        logic [CH_W-1:0]  ch;
        logic [POS_W-1:0] pos;
    } ring_commit_t;

    function automatic logic [LEN_W-1:0] eff_len(input logic [14:0] dl);
        if (dl == 15'd0)
            return LEN_W'(1);
        if (32'(dl) > MAX_DELAY)
            return LEN_W'(MAX_DELAY);
        return LEN_W'(dl);
    endfunction

    function automatic logic channel_ok(input logic [3:0] count, input logic [2:0] ch);
        return (32'(ch) < 32'(count)) && (32'(ch) < MAX_CHANNELS);
    endfunction

    function automatic logic in_q_range(input logic signed [PROD_W:0] v);
        return (v >= Q_MIN) && (v <= Q_MAX);
    endfunction

endpackage

[hw/rtl/mfe_cfg_regs.sv]
// APB register file for the echo unit settings.
// Depends on mfe_pkg for the register layout and reset values.
module mfe_cfg_regs
    import mfe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_CHANNEL_COUNT: cfg_next.channel_count = pwdata[3:0];
                REG_DELAY_LENGTH:  cfg_next.delay_length  = pwdata[14:0];
                REG_LOOP_GAIN:     cfg_next.loop_gain     = pwdata[15:0];
                REG_DELAYED_GAIN:  cfg_next.delayed_gain  = pwdata[15:0];
                REG_DIRECT_GAIN:   cfg_next.direct_gain   = pwdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_CHANNEL_COUNT: prdata = PDATA_W'(cfg_reg.channel_count);
            REG_DELAY_LENGTH:  prdata = PDATA_W'(cfg_reg.delay_length);
            REG_LOOP_GAIN:     prdata = PDATA_W'($unsigned(cfg_reg.loop_gain));
            REG_DELAYED_GAIN:  prdata = PDATA_W'($unsigned(cfg_reg.delayed_gain));
            REG_DIRECT_GAIN:   prdata = PDATA_W'($unsigned(cfg_reg.direct_gain));
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

endmodule

[hw/rtl/mfe_delay_ram.sv]
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module mfe_delay_ram #(
    parameter int DATA_W = 17,
    parameter int ADDR_W = 17
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

endmodule

[hw/rtl/mfe_ring_state.sv]
// Per-channel ring position and fill count of the delay memory.
// Depends on mfe_pkg and the assertion macros header.
`include "multichannel_feedback_echo_unit_defines.svh"

module mfe_ring_state
    import mfe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CH_W-1:0]  lk_ch,
    input  logic [LEN_W-1:0] len,
    input  ring_commit_t     commit,
    output ring_view_t       view
);

    logic [POS_W-1:0] pos_reg  [CH_SLOTS];
    logic [POS_W-1:0] pos_next [CH_SLOTS];
    logic [LEN_W-1:0] fill_reg  [CH_SLOTS];
    logic [LEN_W-1:0] fill_next [CH_SLOTS];
    logic [LEN_W-1:0] inc;
    logic [LEN_W-1:0] base_fill;

    // entries below the fill count were written since the last clear; others read as silence
    assign view.pos  = pos_reg[lk_ch];
    assign view.fill = fill_reg[lk_ch];

    assign inc       = LEN_W'(commit.pos) + LEN_W'(1);
    assign base_fill = commit.clear ? '0 : fill_reg[commit.ch];

    always_comb
    begin
        pos_next  = pos_reg;
        fill_next = fill_reg;
        if (commit.en)
        begin
            if (commit.clear)
            begin
                for (int i = 0; i < CH_SLOTS; i++)
                begin
                    pos_next[i]  = '0;
                    fill_next[i] = '0;
                end
            end
            pos_next[commit.ch]  = (inc >= len) ? '0 : POS_W'(inc);
            fill_next[commit.ch] = (inc > base_fill) ? inc : base_fill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CH_SLOTS; i++)
            begin
                pos_reg[i]  <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            pos_reg  <= pos_next;
            fill_reg <= fill_next;
        end
    end

    `MFE_ASSERT_ALWAYS(a_pos_within_fill, LEN_W'(pos_reg[lk_ch]) <= fill_reg[lk_ch], "ring position beyond written region")

endmodule

[hw/rtl/multichannel_feedback_echo_unit.sv]
// Multichannel feedback echo. Each sample word is echoed per channel from a delay ring held in
// one on-chip RAM: out = (dry*x + wet*d) >> 12, and x + ((fb*d) >> 15) is written back in
// place of d. Words flow through a three-stage pipeline (position lookup and RAM read, gain
// multiplies, sum and range check with write-back) into an output register. Words for different
// channels enter one per cycle while the output is not stalled; a word for a channel that is
// still in the pipeline waits until that word commits its write-back and position. A word with
// restart holds off every later word the same way. Restart and reset clear the rings through
// per-channel fill counts, without a clearing pass.
`include "multichannel_feedback_echo_unit_defines.svh"

module multichannel_feedback_echo_unit
    import mfe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  in_word_t           sample_word,
    output logic               echo_valid,
    input  logic               echo_ready,
    output out_word_t          echo_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic [CH_W-1:0]            ch;
        logic [POS_W-1:0]           pos;
        logic                       restart;
        logic                       dvalid;
        status_t                    status;
    } s1_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic [CH_W-1:0]            ch;
        logic [POS_W-1:0]           pos;
        logic                       restart;
        status_t                    status;
        logic signed [PROD_W-1:0]   p_dry;
        logic signed [PROD_W-1:0]   p_wet;
        logic signed [PROD_W-1:0]   p_fb;
    } s2_t;

    cfg_t         cfg;
    ring_view_t   view;
    ring_commit_t commit;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;
    s1_t       s1_reg, s1_next;
    s2_t       s2_reg, s2_next;
    out_word_t out_word_reg, out_word_next;

    logic             advance;
    logic             hazard;
    logic             accept;
    logic [CH_W-1:0]  in_ch;
    logic [LEN_W-1:0] len;
    logic [POS_W-1:0] pos_live;
    logic [POS_W-1:0] pos0;
    status_t          status0;

    logic [SAMPLE_W-1:0]        rd_data;
    logic signed [SAMPLE_W-1:0] d;
    logic [ADDR_W-1:0]          ram_rd_addr;
    logic [ADDR_W-1:0]          ram_wr_addr;
    logic                       ram_we;

    logic signed [PROD_W:0]     mix;
    logic signed [21:0]         y;
    logic signed [17:0]         fb_term;
    logic signed [18:0]         st;
    status_t                    status2;
    out_word_t                  result;

    mfe_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mfe_ring_state u_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .lk_ch  (in_ch),
        .len    (len),
        .commit (commit),
        .view   (view)
    );

    mfe_delay_ram #(
        .DATA_W (SAMPLE_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (st[SAMPLE_W-1:0]),
        .rd_en   (accept),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_data)
    );

    // stage 0: status checks, position lookup, RAM read
    assign advance = !out_valid_reg || echo_ready;
    assign in_ch   = CH_W'(sample_word.channel);
    assign hazard  = (s1_valid_reg && (s1_reg.restart || s1_reg.ch == in_ch)) ||
                     (s2_valid_reg && (s2_reg.restart || s2_reg.ch == in_ch));
    assign sample_ready = advance && !hazard;
    assign accept       = sample_valid && sample_ready;

    assign len      = eff_len(cfg.delay_length);
    assign pos_live = (LEN_W'(view.pos) >= len) ? '0 : view.pos;
    assign pos0     = sample_word.restart ? '0 : pos_live;
    assign ram_rd_addr = {in_ch, pos0};

    always_comb
    begin
        if (!channel_ok(cfg.channel_count, sample_word.channel))
            status0 = ST_BAD_CHANNEL;
        else if (!in_q_range((PROD_W+1)'(sample_word.sample_in)))
            status0 = ST_INPUT_RANGE;
        else
            status0 = ST_OK;
    end

    // stage 1: gain products
    assign d = s1_reg.dvalid ? $signed(rd_data) : '0;

    // stage 2: mix, range check, write-back
    assign mix     = (PROD_W+1)'(s2_reg.p_dry) + (PROD_W+1)'(s2_reg.p_wet);
    assign y       = 22'(mix >>> 12);
    assign fb_term = 18'(s2_reg.p_fb >>> 15);
    assign st      = 19'(s2_reg.x) + 19'(fb_term);

    always_comb
    begin
        if (s2_reg.status != ST_OK)
            status2 = s2_reg.status;
        else if (in_q_range((PROD_W+1)'(y)) && in_q_range((PROD_W+1)'(st)))
            status2 = ST_OK;
        else
            status2 = ST_RESULT_RANGE;
    end

    always_comb
    begin
        result.status     = status2;
        result.sample_out = (status2 == ST_OK) ? y[SAMPLE_W-1:0] : '0;
        result.restarted  = (status2 == ST_OK) && s2_reg.restart;
    end

    assign ram_we       = s2_valid_reg && advance && (status2 == ST_OK);
    assign ram_wr_addr  = {s2_reg.ch, s2_reg.pos};
    assign commit.en    = ram_we;
    assign commit.clear = s2_reg.restart;
    assign commit.ch    = s2_reg.ch;
    assign commit.pos   = s2_reg.pos;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s2_valid_next  = s2_valid_reg;
        out_valid_next = out_valid_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        out_word_next  = out_word_reg;
        if (advance)
        begin
            s1_valid_next  = accept;
            s1_next.x       = sample_word.sample_in;
            s1_next.ch      = in_ch;
            s1_next.pos     = pos0;
            s1_next.restart = sample_word.restart;
            s1_next.dvalid  = !sample_word.restart && (LEN_W'(pos0) < view.fill);
            s1_next.status  = status0;

            s2_valid_next  = s1_valid_reg;
            s2_next.x       = s1_reg.x;
            s2_next.ch      = s1_reg.ch;
            s2_next.pos     = s1_reg.pos;
            s2_next.restart = s1_reg.restart;
            s2_next.status  = s1_reg.status;
            s2_next.p_dry   = PROD_W'(s1_reg.x) * PROD_W'(cfg.direct_gain);
            s2_next.p_wet   = PROD_W'(d) * PROD_W'(cfg.delayed_gain);
            s2_next.p_fb    = PROD_W'(d) * PROD_W'(cfg.loop_gain);

            out_valid_next = s2_valid_reg;
            out_word_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg       <= s1_next;
        s2_reg       <= s2_next;
        out_word_reg <= out_word_next;
    end

    assign echo_valid = out_valid_reg;
    assign echo_word  = out_word_reg;

    `MFE_ASSERT_IMPLIES(a_no_rw_collision, ram_we && accept, ram_wr_addr != ram_rd_addr, "RAM read and write hit the same entry")
    `MFE_ASSERT_IMPLIES(a_out_from_pipe, $rose(echo_valid), $past(s2_valid_reg), "result appeared without a word in the last stage")
    `MFE_ASSERT_IMPLIES(a_error_silent, echo_valid && echo_word.status != ST_OK, echo_word.sample_out == '0 && !echo_word.restarted, "failed word carries data")

endmodule
